// ===== hdl/b64d_pkg.sv =====
// Package with the shared types, constants and the alphabet decode function of the decoder.
package b64d_pkg;

    localparam logic [7:0]  PAD_CHAR    = 8'h3D;
    localparam logic [23:0] TOTAL_MAX   = 24'hFFFFFF;
    localparam int          QUEUE_DEPTH = 4;

    // One queue entry: the bytes of one character and how the back end reports them.
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [1:0]  nbytes;
        logic        done;
        logic [23:0] total;
    } op_t;

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        begin
            r = 7'b100_0000;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                r = {1'b0, 6'(c - 8'h41)};
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                r = {1'b0, 6'(c - 8'h61 + 8'd26)};
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b0, 6'(c - 8'h30 + 8'd52)};
            end
            else if (c == 8'h2B)
            begin
                r = {1'b0, 6'd62};
            end
            else if (c == 8'h2F)
            begin
                r = {1'b0, 6'd63};
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/b64d_ifs.sv =====
// Channel interfaces for the character input and the decoded byte output.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       msg_start;
    logic       msg_end;

    modport source (output valid, output char_in, output msg_start, output msg_end,
                    input ready);
    modport sink   (input valid, input char_in, input msg_start, input msg_end,
                    output ready);
endinterface

interface b64d_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        run_last;
    logic        message_done;
    logic [23:0] total_bytes;

    modport source (output valid, output data_byte, output byte_valid, output run_last,
                    output message_done, output total_bytes, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input run_last,
                    input message_done, input total_bytes, output ready);
endinterface

// ===== hdl/b64d_front.sv =====
// Front end: accepts characters, keeps the group state and queues the bytes each one releases.
module b64d_front
(
    input  logic             clk,
    input  logic             rst_n,
    b64d_char_if.sink        char_chan,
    input  logic             queue_full,
    output logic             push,
    output b64d_pkg::op_t    push_op
);

    logic [1:0]  phase_reg, phase_next, phase_eff;
    logic [5:0]  s0_reg, s0_next, s0_eff;
    logic [5:0]  s1_reg, s1_next, s1_eff;
    logic [5:0]  s2_reg, s2_next, s2_eff;
    logic        pad_reg, pad_next, pad_eff;
    logic [23:0] total_reg, total_next, total_eff;
    logic [6:0]  sx;
    logic [1:0]  nbytes;
    logic [24:0] sum;
    logic        accept;

    assign char_chan.ready = !queue_full;
    assign accept          = char_chan.valid && !queue_full;

    always_comb
    begin
        phase_eff = char_chan.msg_start ? 2'd0  : phase_reg;
        s0_eff    = char_chan.msg_start ? 6'd0  : s0_reg;
        s1_eff    = char_chan.msg_start ? 6'd0  : s1_reg;
        s2_eff    = char_chan.msg_start ? 6'd0  : s2_reg;
        pad_eff   = char_chan.msg_start ? 1'b0  : pad_reg;
        total_eff = char_chan.msg_start ? 24'd0 : total_reg;
        sx        = b64d_pkg::sextet_of(char_chan.char_in);

        phase_next = phase_eff;
        s0_next    = s0_eff;
        s1_next    = s1_eff;
        s2_next    = s2_eff;
        pad_next   = pad_eff;
        nbytes     = 2'd0;

        if (!pad_eff)
        begin
            if (char_chan.char_in == b64d_pkg::PAD_CHAR)
            begin
                case (phase_eff) inside
                    2'd1, 2'd2: nbytes = 2'd1;
                    2'd3:       nbytes = 2'd2;
                    default:    nbytes = 2'd0;
                endcase
                phase_next = 2'd0;
                s0_next    = 6'd0;
                s1_next    = 6'd0;
                s2_next    = 6'd0;
                pad_next   = 1'b1;
            end
            else if (!sx[6])
            begin
                if (phase_eff == 2'd3)
                begin
                    nbytes     = 2'd3;
                    phase_next = 2'd0;
                    s0_next    = 6'd0;
                    s1_next    = 6'd0;
                    s2_next    = 6'd0;
                end
                else
                begin
                    case (phase_eff)
                        2'd0:    s0_next = sx[5:0];
                        2'd1:    s1_next = sx[5:0];
                        default: s2_next = sx[5:0];
                    endcase
                    phase_next = phase_eff + 2'd1;
                end
            end
        end

        if (char_chan.msg_end)
        begin
            phase_next = 2'd0;
            s0_next    = 6'd0;
            s1_next    = 6'd0;
            s2_next    = 6'd0;
        end

        sum        = {1'b0, total_eff} + 25'(nbytes);
        total_next = (sum > {1'b0, b64d_pkg::TOTAL_MAX}) ? b64d_pkg::TOTAL_MAX : sum[23:0];

        push_op.byte0  = {s0_eff, s1_eff[5:4]};
        push_op.byte1  = {s1_eff[3:0], s2_eff[5:2]};
        push_op.byte2  = {s2_eff[1:0], sx[5:0]};
        push_op.nbytes = nbytes;
        push_op.done   = char_chan.msg_end;
        push_op.total  = total_next;
        push           = accept && ((nbytes != 2'd0) || char_chan.msg_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            s0_reg    <= 6'd0;
            s1_reg    <= 6'd0;
            s2_reg    <= 6'd0;
            pad_reg   <= 1'b0;
            total_reg <= 24'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            s0_reg    <= s0_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            pad_reg   <= pad_next;
            total_reg <= total_next;
        end
    end

endmodule

// ===== hdl/b64d_queue.sv =====
// Short first-in first-out queue of byte entries between the front and back ends.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b64d_pkg::op_t push_op,
    input  logic          pop,
    output b64d_pkg::op_t head_op,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::op_t  entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/b64d_back.sv =====
// Back end: takes queue entries and hands out their results one word per cycle while the output is ready.
module b64d_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  b64d_pkg::op_t  head_op,
    input  logic           queue_empty,
    output logic           pop,
    b64d_byte_if.source    byte_chan
);

    b64d_pkg::op_t cur_reg;
    logic          cur_valid_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    last_idx;
    logic          at_last, fire, free;
    logic [7:0]    sel_byte;

    assign last_idx = (cur_reg.nbytes == 2'd0) ? 2'd0 : cur_reg.nbytes - 2'd1;
    assign at_last  = (idx_reg == last_idx);
    assign fire     = cur_valid_reg && byte_chan.ready;
    assign free     = !cur_valid_reg || (fire && at_last);
    assign pop      = free && !queue_empty;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.byte0;
            2'd1:    sel_byte = cur_reg.byte1;
            default: sel_byte = cur_reg.byte2;
        endcase
    end

    assign byte_chan.valid        = cur_valid_reg;
    assign byte_chan.byte_valid   = (cur_reg.nbytes != 2'd0);
    assign byte_chan.data_byte    = (cur_reg.nbytes != 2'd0) ? sel_byte : 8'd0;
    assign byte_chan.run_last     = at_last;
    assign byte_chan.message_done = at_last && cur_reg.done;
    assign byte_chan.total_bytes  = (at_last && cur_reg.done) ? cur_reg.total : 24'd0;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (free)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Top level of the streaming Base64 decoder: front end, entry queue and back end.
// A character is taken every cycle while the queue has room; its result words go into the
// queue and then into the back end's output register before they are offered. Results leave
// at one word per cycle while the output is ready, and a group of four characters yields
// three words, so a steady stream runs at one character per cycle. Reset clears the group
// state, byte count, queue and output stage at once; there is no clearing pass.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   char_chan,
    b64d_byte_if.source byte_chan
);

    b64d_pkg::op_t push_op;
    b64d_pkg::op_t head_op;
    logic          push, pop, full, empty;

    b64d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_chan),
        .queue_full (full),
        .push       (push),
        .push_op    (push_op)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .full    (full),
        .empty   (empty)
    );

    b64d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .queue_empty (empty),
        .pop         (pop),
        .byte_chan   (byte_chan)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Base64 stream decoder: directed and random messages.
module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 240;
    localparam bit [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        run_last;
        logic        message_done;
        logic [23:0] total_bytes;
    } byte_word_t;

    typedef bit [7:0] char_run_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    b64d_char_if char_chan();
    b64d_byte_if byte_chan();

    assign byte_chan.ready = sink_ready;

    base64_stream_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_chan),
        .byte_chan (byte_chan)
    );

    logic [1:0]  held_count;
    logic [5:0]  held_sextet [3];
    logic        pad_hit;
    logic [23:0] msg_bytes;

    byte_word_t awaited_words[$];

    int sender_idle = 0;
    int receiver_idle = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int chars_sent = 0;
    int messages_sent = 0;
    int words_checked = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] symbol(input int idx);
        return ALPHABET[8*(63-idx) +: 8];
    endfunction

    function automatic int alphabet_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (symbol(i) == c)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void clear_group();
        held_count = 2'd0;
        held_sextet[0] = 6'd0;
        held_sextet[1] = 6'd0;
        held_sextet[2] = 6'd0;
    endfunction

    // Works out the result words that one accepted character causes.
    function automatic void decode_char(input logic [7:0] c, input logic s, input logic e);
        byte_word_t burst [3];
        logic [7:0] out_b [3];
        logic [5:0] s0;
        logic [5:0] s1;
        logic [5:0] s2;
        int nb;
        int v;
        nb = 0;
        if (s)
        begin
            clear_group();
            pad_hit = 1'b0;
            msg_bytes = 24'd0;
        end
        s0 = held_sextet[0];
        s1 = held_sextet[1];
        s2 = held_sextet[2];
        if (!pad_hit)
        begin
            if (c == b64d_pkg::PAD_CHAR)
            begin
                if (held_count != 2'd0)
                begin
                    out_b[0] = {s0, s1[5:4]};
                    nb = 1;
                end
                if (held_count == 2'd3)
                begin
                    out_b[1] = {s1[3:0], s2[5:2]};
                    nb = 2;
                end
                clear_group();
                pad_hit = 1'b1;
            end
            else
            begin
                v = alphabet_index(c);
                if (v >= 0 && held_count == 2'd3)
                begin
                    out_b[0] = {s0, s1[5:4]};
                    out_b[1] = {s1[3:0], s2[5:2]};
                    out_b[2] = {s2[1:0], v[5:0]};
                    nb = 3;
                    clear_group();
                end
                else if (v >= 0)
                begin
                    held_sextet[held_count] = v[5:0];
                    held_count = held_count + 2'd1;
                end
            end
        end
        for (int i = 0; i < nb; i++)
        begin
            burst[i] = '0;
            burst[i].data_byte = out_b[i];
            burst[i].byte_valid = 1'b1;
            if (msg_bytes != b64d_pkg::TOTAL_MAX)
            begin
                msg_bytes = msg_bytes + 24'd1;
            end
        end
        if (e)
        begin
            clear_group();
            if (nb == 0)
            begin
                burst[0] = '0;
                nb = 1;
            end
            burst[nb-1].message_done = 1'b1;
            burst[nb-1].total_bytes = msg_bytes;
        end
        if (nb > 0)
        begin
            burst[nb-1].run_last = 1'b1;
        end
        for (int i = 0; i < nb; i++)
        begin
            awaited_words.push_back(burst[i]);
        end
    endfunction

    task automatic send_word(input logic [7:0] c, input logic s, input logic e);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            char_chan.valid <= 1'b0;
            @(posedge clk);
        end
        char_chan.valid <= 1'b1;
        char_chan.char_in <= c;
        char_chan.msg_start <= s;
        char_chan.msg_end <= e;
        @(posedge clk);
        while (!char_chan.ready)
        begin
            @(posedge clk);
        end
        decode_char(c, s, e);
        chars_sent++;
    endtask

    task automatic send_run(input char_run_t chars, input logic with_start);
        for (int i = 0; i < chars.size(); i++)
        begin
            send_word(chars[i], with_start && (i == 0), i == chars.size() - 1);
        end
        messages_sent++;
    endtask

    task automatic wait_drained();
        char_chan.valid <= 1'b0;
        while (awaited_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        @(negedge clk);
        sender_idle = src_pct;
        receiver_idle = snk_pct;
        @(posedge clk);
    endtask

    // Mostly well-formed messages with random content, some stray characters and padding.
    task automatic send_random_message();
        char_run_t chars;
        int nsym;
        int pad;
        nsym = $urandom_range(1, 14);
        pad = $urandom_range(0, 3);
        for (int i = 0; i < nsym; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
            chars.push_back(symbol($urandom_range(0, 63)));
        end
        if (pad >= 2)
        begin
            chars.push_back(b64d_pkg::PAD_CHAR);
        end
        if (pad == 3)
        begin
            chars.push_back(b64d_pkg::PAD_CHAR);
        end
        if (pad >= 2 && $urandom_range(0, 3) == 0)
        begin
            chars.push_back(symbol($urandom_range(0, 63)));
        end
        send_run(chars, $urandom_range(0, 9) != 0);
    endtask

    task automatic test_directed();
        send_run('{"T", "W", "F", "u"}, 1'b1);
        send_run('{"T", "Q", "=", "="}, 1'b1);
        send_run('{"T", "="}, 1'b1);
        send_run('{"A", 8'h00, 8'hFF, "-", "+", "/", "="}, 1'b1);
        send_run('{"Z", "a", "z", "9", "="}, 1'b1);
        send_run('{"T", "W"}, 1'b1);
        send_run('{"="}, 1'b1);
        send_run('{"Q"}, 1'b0);
        send_run('{"B"}, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_stream(input int count);
        int first;
        first = chars_sent;
        while (chars_sent - first < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                send_random_message();
            end
        end
        wait_drained();
    endtask

    task automatic test_long_stall();
        @(negedge clk);
        hold_seq = hold_seq + 1;
        @(posedge clk);
        test_random_stream(30);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            sink_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    always @(posedge clk)
    begin
        byte_word_t want;
        if (rst_n && byte_chan.valid && byte_chan.ready)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("unexpected word: data_byte %0h, message_done %0b",
                       byte_chan.data_byte, byte_chan.message_done);
                error_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (byte_chan.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte,
                           byte_chan.data_byte);
                    error_count++;
                end
                if (byte_chan.byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                           byte_chan.byte_valid);
                    error_count++;
                end
                if (byte_chan.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last,
                           byte_chan.run_last);
                    error_count++;
                end
                if (byte_chan.message_done !== want.message_done)
                begin
                    $error("message_done: expected %0b, got %0b", want.message_done,
                           byte_chan.message_done);
                    error_count++;
                end
                if (byte_chan.total_bytes !== want.total_bytes)
                begin
                    $error("total_bytes: expected %0d, got %0d", want.total_bytes,
                           byte_chan.total_bytes);
                    error_count++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_chan.valid && char_chan.ready) ||
            (byte_chan.valid && byte_chan.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        char_chan.valid <= 1'b0;
        char_chan.char_in <= 8'h00;
        char_chan.msg_start <= 1'b0;
        char_chan.msg_end <= 1'b0;
        clear_group();
        pad_hit = 1'b0;
        msg_bytes = 24'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(37, 65);
        test_directed();
        test_random_stream(95);
        set_idling(65, 37);
        test_random_stream(70);
        test_long_stall();
        set_idling(0, 0);
        test_random_stream(90);
        $display("Sent %0d characters in %0d messages and checked %0d result words.",
                 chars_sent, messages_sent, words_checked);
        $display("Padding, skipped characters, dropped groups, continuations and a long %s",
                 "output stall were exercised under three idling mixes.");
        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
